[design/lzss_ring_decoder_top_defines.svh]
// Assertion macros used by the decoder's checker file.
`ifndef LZSS_RING_DECODER_TOP_DEFINES_SVH
`define LZSS_RING_DECODER_TOP_DEFINES_SVH

// Same-cycle implication, ignored while reset is high.
`define LZRD_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lzrd assertion failed");

// Next-cycle implication, ignored while reset is high.
`define LZRD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lzrd assertion failed");

// Next-cycle implication that also holds across reset.
`define LZRD_ASSERT_ALWAYS_NEXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("lzrd assertion failed");

`endif

[design/lzrd_pkg.sv]
// Shared types and constants of the LZSS ring decoder.
package lzrd_pkg;

   localparam int RING_DEPTH  = 4096;
   localparam int RING_AW     = $clog2(RING_DEPTH);
   localparam logic [RING_AW-1:0] RING_START = RING_AW'(12'hFEE);
   localparam int MATCH_MIN   = 3;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   // Command codes passed from the parser to the copy engine
   typedef enum logic [1:0] {
      OP_LITERAL = 2'd0,
      OP_MATCH   = 2'd1,
      OP_RESTART = 2'd2
   } op_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       final_byte;
   } req_payload_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic [31:0] out_count;
      logic        run_last;
   } rsp_payload_type;

   typedef struct packed {
      op_type             op;
      logic [7:0]         data;
      logic [RING_AW-1:0] offset;
      logic [3:0]         len_code;
      logic               stream_end;
   } cmd_type;

endpackage

[design/lzrd_front.sv]
// Parser: accepts payload bytes, tracks flag bits and issues commands.
module lzrd_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  lzrd_pkg::req_payload_type req_payload,
   input  logic                     q_full,
   output logic                     push,
   output lzrd_pkg::cmd_type        push_cmd
);
   import lzrd_pkg::*;

   typedef enum logic [1:0] {
      PH_FLAG   = 2'd0,
      PH_ITEM   = 2'd1,
      PH_MATCH2 = 2'd2
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [7:0] flag_bits_ff, flag_bits_in;
   logic [2:0] flag_idx_ff, flag_idx_in;
   logic [7:0] held_ff, held_in;
   logic       accept;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   // Classify the incoming byte and build the command for the copy engine
   always_comb begin
      phase_in     = phase_ff;
      flag_bits_in = flag_bits_ff;
      flag_idx_in  = flag_idx_ff;
      held_in      = held_ff;
      push         = 1'b0;
      push_cmd     = '0;
      push_cmd.op  = OP_RESTART;
      push_cmd.stream_end = req_payload.final_byte;
      if (accept) begin
         unique case (phase_ff)
            PH_FLAG: begin
               flag_bits_in = req_payload.in_byte;
               flag_idx_in  = '0;
               phase_in     = PH_ITEM;
               push         = req_payload.final_byte;
            end
            PH_ITEM: begin
               if (!flag_bits_ff[~flag_idx_ff]) begin
                  push          = 1'b1;
                  push_cmd.op   = OP_LITERAL;
                  push_cmd.data = req_payload.in_byte;
                  flag_idx_in   = flag_idx_ff + 3'd1;
                  phase_in      = (flag_idx_ff == 3'd7) ? PH_FLAG : PH_ITEM;
               end else begin
                  held_in  = req_payload.in_byte;
                  phase_in = PH_MATCH2;
                  // cut-short match: only the restart survives
                  push     = req_payload.final_byte;
               end
            end
            PH_MATCH2: begin
               push              = 1'b1;
               push_cmd.op       = OP_MATCH;
               push_cmd.offset   = {req_payload.in_byte[7:4], held_ff};
               push_cmd.len_code = req_payload.in_byte[3:0];
               flag_idx_in       = flag_idx_ff + 3'd1;
               phase_in          = (flag_idx_ff == 3'd7) ? PH_FLAG : PH_ITEM;
            end
            default: begin
               phase_in = PH_FLAG;
            end
         endcase
         // end of stream: parser returns to its start state
         if (req_payload.final_byte) begin
            phase_in     = PH_FLAG;
            flag_bits_in = '0;
            flag_idx_in  = '0;
            held_in      = '0;
         end
      end
   end

   // Parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_FLAG;
         flag_bits_ff <= '0;
         flag_idx_ff  <= '0;
         held_ff      <= '0;
      end else begin
         phase_ff     <= phase_in;
         flag_bits_ff <= flag_bits_in;
         flag_idx_ff  <= flag_idx_in;
         held_ff      <= held_in;
      end
   end

endmodule

[design/lzrd_queue.sv]
// Short command FIFO between the parser and the copy engine.
module lzrd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  lzrd_pkg::cmd_type push_cmd,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output lzrd_pkg::cmd_type head_cmd
);
   import lzrd_pkg::*;

   cmd_type             slots_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]   count_ff, count_in;

   assign full       = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = slots_ff[rd_ptr_ff];

   // Pointer and occupancy update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Command storage
   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

[design/lzrd_back.sv]
// Copy engine: history ring, match copy and the result register.
module lzrd_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      head_valid,
   input  lzrd_pkg::cmd_type         head_cmd,
   output logic                      pop,
   input  logic [31:0]               out_limit,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output lzrd_pkg::rsp_payload_type rsp_payload
);
   import lzrd_pkg::*;

   logic [7:0] ring_mem [RING_DEPTH];
   logic [7:0] rd_data_ff;

   // Ring bookkeeping
   logic [RING_AW-1:0] wp_ff, wp_in;
   logic [RING_AW:0]   fill_ff, fill_in;
   logic [31:0]        count_ff, count_in;
   logic [4:0]         idx_ff, idx_in;

   // Byte stage: one produced byte waiting for write and emission
   logic       b_valid_ff, b_valid_in;
   logic       b_has_byte_ff, b_has_byte_in;
   logic       b_from_mem_ff, b_from_mem_in;
   logic       b_hit_ff, b_hit_in;
   logic [7:0] b_data_ff, b_data_in;
   logic       b_last_ff, b_last_in;
   logic       b_end_ff, b_end_in;

   // Result register
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_payload_ff, rsp_payload_in;

   logic [7:0]         b_byte;
   logic [31:0]        count_next;
   logic               emit_ok, slot_free, b_adv, wr_en, emit, b_free, issue;
   logic               is_match, match_done, rd_en, hit, fwd;
   logic [4:0]         last_idx;
   logic [RING_AW-1:0] rd_addr, rel;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // Byte stage retire: write the ring, emit while under the limit
   assign b_byte     = b_from_mem_ff ? (b_hit_ff ? rd_data_ff : 8'h00) : b_data_ff;
   assign count_next = count_ff + 32'd1;
   assign emit_ok    = count_ff < out_limit;
   assign slot_free  = !rsp_valid_ff || !rsp_stall;
   assign b_adv      = b_valid_ff && (!b_has_byte_ff || !emit_ok || slot_free);
   assign wr_en      = b_adv && b_has_byte_ff;
   assign emit       = wr_en && emit_ok;
   assign b_free     = !b_valid_ff || b_adv;

   // Command issue; a new stream waits until the old one has closed
   assign issue      = head_valid && b_free && !(b_valid_ff && b_end_ff);
   assign is_match   = (head_cmd.op == OP_MATCH);
   assign last_idx   = {1'b0, head_cmd.len_code} + 5'(MATCH_MIN - 1);
   assign match_done = (idx_ff == last_idx);
   assign pop        = issue && (!is_match || match_done);
   assign rd_en      = issue && is_match;
   assign rd_addr    = head_cmd.offset + RING_AW'(idx_ff);

   // Entries outside the written span still read as zero
   assign rel = rd_addr - RING_START;
   assign hit = fill_ff[RING_AW] || (rel < fill_ff[RING_AW-1:0]);
   // Byte written this cycle is the one being read
   assign fwd = wr_en && (rd_addr == wp_ff);

   always_comb begin
      b_valid_in    = b_valid_ff;
      b_has_byte_in = b_has_byte_ff;
      b_from_mem_in = b_from_mem_ff;
      b_hit_in      = b_hit_ff;
      b_data_in     = b_data_ff;
      b_last_in     = b_last_ff;
      b_end_in      = b_end_ff;
      idx_in        = idx_ff;
      if (issue) begin
         b_valid_in = 1'b1;
         unique case (head_cmd.op)
            OP_LITERAL: begin
               b_has_byte_in = 1'b1;
               b_from_mem_in = 1'b0;
               b_hit_in      = 1'b0;
               b_data_in     = head_cmd.data;
               b_last_in     = 1'b1;
               b_end_in      = head_cmd.stream_end;
            end
            OP_MATCH: begin
               b_has_byte_in = 1'b1;
               b_from_mem_in = !fwd;
               b_hit_in      = hit;
               b_data_in     = b_byte;
               b_last_in     = match_done;
               b_end_in      = head_cmd.stream_end && match_done;
               idx_in        = match_done ? 5'd0 : idx_ff + 5'd1;
            end
            OP_RESTART: begin
               b_has_byte_in = 1'b0;
               b_from_mem_in = 1'b0;
               b_hit_in      = 1'b0;
               b_last_in     = 1'b0;
               b_end_in      = 1'b1;
            end
            default: begin
               b_has_byte_in = 1'b0;
               b_from_mem_in = 1'b0;
               b_hit_in      = 1'b0;
               b_last_in     = 1'b0;
               b_end_in      = 1'b0;
            end
         endcase
      end else if (b_adv) begin
         b_valid_in = 1'b0;
      end
   end

   // Write position, fill count and emitted count
   always_comb begin
      priority if (b_adv && b_end_ff) begin
         wp_in    = RING_START;
         fill_in  = '0;
         count_in = '0;
      end else if (wr_en) begin
         wp_in    = wp_ff + 1'b1;
         fill_in  = fill_ff[RING_AW] ? fill_ff : fill_ff + 1'b1;
         count_in = emit ? count_next : count_ff;
      end else begin
         wp_in    = wp_ff;
         fill_in  = fill_ff;
         count_in = count_ff;
      end
   end

   // Result register
   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      if (emit) begin
         rsp_valid_in             = 1'b1;
         rsp_payload_in.out_byte  = b_byte;
         rsp_payload_in.out_count = count_next;
         rsp_payload_in.run_last  = b_last_ff || (count_next == out_limit);
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff        <= RING_START;
         fill_ff      <= '0;
         count_ff     <= '0;
         idx_ff       <= '0;
         b_valid_ff   <= 1'b0;
         b_end_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wp_ff        <= wp_in;
         fill_ff      <= fill_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         b_valid_ff   <= b_valid_in;
         b_end_ff     <= b_end_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      b_has_byte_ff  <= b_has_byte_in;
      b_from_mem_ff  <= b_from_mem_in;
      b_hit_ff       <= b_hit_in;
      b_data_ff      <= b_data_in;
      b_last_ff      <= b_last_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   // History ring: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_mem[wp_ff] <= b_byte;
      end
      if (rd_en) begin
         rd_data_ff <= ring_mem[rd_addr];
      end
   end

endmodule

[design/lzss_ring_decoder_top.sv]
// LZSS decoder with a 4096-byte history ring: parser, command queue, copy engine.
// The parser takes one compressed byte per cycle while its four-entry command queue
// has room; flag bytes and first match bytes not marked final only update parser state.
// The copy engine behind the queue produces one decompressed byte per cycle unless its
// output stalls; a match of length L (3 to 18) gives L bytes from the single ring read
// port, read once per match byte, with the byte written in the same cycle forwarded to
// a read of that address. A byte marked final closes the stream; the next stream's
// first command waits until the final entry has left the byte stage. The ring needs no
// clearing pass after reset or between streams: a fill count marks which entries the
// current stream has written, and all others read as zero. Results wait in an output
// register; while it is stalled the engine can still move one byte into its byte stage
// and then waits, except that bytes past the limit never wait for it. The user must
// write out_limit through csr_we/csr_wdata only while the block is idle; the block does
// not enforce this. Bytes past the limit still enter the ring but are not emitted.
module lzss_ring_decoder_top (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  lzrd_pkg::req_payload_type req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output lzrd_pkg::rsp_payload_type rsp_payload,
   input  logic                      csr_we,
   input  logic [31:0]               csr_wdata
);
   import lzrd_pkg::*;

   logic [31:0] out_limit_ff;
   logic        q_full, push, pop, head_valid;
   cmd_type     push_cmd, head_cmd;

   // Output limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_limit_ff <= '1;
      end else if (csr_we) begin
         out_limit_ff <= csr_wdata;
      end
   end

   lzrd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .q_full      (q_full),
      .push        (push),
      .push_cmd    (push_cmd)
   );

   lzrd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   lzrd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (head_valid),
      .head_cmd    (head_cmd),
      .pop         (pop),
      .out_limit   (out_limit_ff),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

[design/lzrd_checker.sv]
// Port-level checker for the decoder top level and its bind.
`include "lzss_ring_decoder_top_defines.svh"

module lzrd_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_stall,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input lzrd_pkg::rsp_payload_type rsp_payload
);

   // Nothing pending and room for input right after reset
   `LZRD_ASSERT_ALWAYS_NEXT(a_rsp_idle_after_reset, clock, reset, !rsp_valid)
   `LZRD_ASSERT_ALWAYS_NEXT(a_req_open_after_reset, clock, reset, !req_stall)

   // Every emitted byte carries a running count of at least one
   `LZRD_ASSERT_IMP(a_count_nonzero, clock, reset, rsp_valid, rsp_payload.out_count != 32'd0)

   // A stalled transaction stays offered unchanged
   `LZRD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload))

endmodule

bind lzss_ring_decoder_top lzrd_checker u_lzrd_checker (.*);
